FILE: src/rgb_yuv_luma_shift_core_defines.svh
// assertion macros for the rgb yuv luma shift core
`ifndef RGB_YUV_LUMA_SHIFT_CORE_DEFINES_SVH
`define RGB_YUV_LUMA_SHIFT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define RYS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rys assertion failed");

`define RYS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rys implication failed");

`else

`define RYS_ASSERT(lbl, clk, rstn, prop)

`define RYS_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: src/rys_pkg.sv
// shared constants, types and helpers for the rgb yuv luma shift core
`timescale 1ns / 1ps
`default_nettype none

package rys_pkg;

  localparam int COEF_FRAC_BITS = 12;
  localparam int CH_W           = 8;
  localparam int YUV_W          = 14;
  localparam int YS_W           = 15;
  localparam int OFS_W          = 13;
  localparam int CLAMP_W        = 16;

  localparam logic [0:0] REG_LUMA_OFFSET = 1'b0;

  typedef struct packed {
    logic                    valid;
    logic signed [YUV_W-1:0] y;
    logic signed [YUV_W-1:0] u;
    logic signed [YUV_W-1:0] v;
  } yuv_t;

  function automatic int milli_to_coef(input int m, input int f);
    milli_to_coef = ((m << f) + 500) / 1000;
  endfunction

  function automatic logic [CH_W-1:0] clamp_byte(input logic signed [CLAMP_W-1:0] val);
    if (val < 0) begin
      clamp_byte = '0;
    end else if (val > 255) begin
      clamp_byte = '1;
    end else begin
      clamp_byte = val[CH_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/rys_if.sv
// pixel input and result output channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface rys_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

interface rys_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray_out;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, output gray_out, output red_out, output green_out,
                  output blue_out, input ready);
  modport sink (input valid, input gray_out, input red_out, input green_out,
                input blue_out, output ready);
endinterface

`default_nettype wire

FILE: src/rys_cfg.sv
// apb register holding the luma offset
`timescale 1ns / 1ps
`default_nettype none

module rys_cfg
  import rys_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic      [31:0]             prdata,
  output logic                         pready,
  output logic signed [OFS_W-1:0]      luma_offset_o
);

  logic signed [OFS_W-1:0] ofs_q, ofs_d;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_LUMA_OFFSET);

  always_comb begin
    ofs_d = ofs_q;
    if (wr_en) begin
      ofs_d = pwdata[OFS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q <= '0;
    end else begin
      ofs_q <= ofs_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LUMA_OFFSET) begin
      prdata = 32'(ofs_q);
    end
  end

  assign luma_offset_o = ofs_q;

endmodule

`default_nettype wire

FILE: src/rys_fwd.sv
// first stage: rgb to yuv with four fractional bits
`timescale 1ns / 1ps
`default_nettype none

module rys_fwd
  import rys_pkg::*;
#(
  parameter int CoefFracBits = COEF_FRAC_BITS
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [CH_W-1:0] red_i,
  input  wire logic [CH_W-1:0] green_i,
  input  wire logic [CH_W-1:0] blue_i,
  output yuv_t                 yuv_o
);

  localparam int FW    = CoefFracBits + 14;
  localparam int DownSh = CoefFracBits - 4;

  localparam logic signed [FW-1:0] C299 = FW'(milli_to_coef(299, CoefFracBits));
  localparam logic signed [FW-1:0] C587 = FW'(milli_to_coef(587, CoefFracBits));
  localparam logic signed [FW-1:0] C114 = FW'(milli_to_coef(114, CoefFracBits));
  localparam logic signed [FW-1:0] C147 = FW'(milli_to_coef(147, CoefFracBits));
  localparam logic signed [FW-1:0] C289 = FW'(milli_to_coef(289, CoefFracBits));
  localparam logic signed [FW-1:0] C436 = FW'(milli_to_coef(436, CoefFracBits));
  localparam logic signed [FW-1:0] C615 = FW'(milli_to_coef(615, CoefFracBits));
  localparam logic signed [FW-1:0] C515 = FW'(milli_to_coef(515, CoefFracBits));
  localparam logic signed [FW-1:0] C100 = FW'(milli_to_coef(100, CoefFracBits));

  logic signed [FW-1:0] r_s, g_s, b_s;
  logic signed [FW-1:0] sum_y, sum_u, sum_v;
  logic signed [FW-1:0] sh_y, sh_u, sh_v;
  yuv_t                 yuv_q, yuv_d;

  assign r_s = FW'($signed({1'b0, red_i}));
  assign g_s = FW'($signed({1'b0, green_i}));
  assign b_s = FW'($signed({1'b0, blue_i}));

  assign sum_y = C299 * r_s + C587 * g_s + C114 * b_s;
  assign sum_u = C436 * b_s - C147 * r_s - C289 * g_s;
  assign sum_v = C615 * r_s - C515 * g_s - C100 * b_s;

  // arithmetic shift floors toward minus infinity
  assign sh_y = sum_y >>> DownSh;
  assign sh_u = sum_u >>> DownSh;
  assign sh_v = sum_v >>> DownSh;

  always_comb begin
    yuv_d.valid = valid_i;
    yuv_d.y     = sh_y[YUV_W-1:0];
    yuv_d.u     = sh_u[YUV_W-1:0];
    yuv_d.v     = sh_v[YUV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yuv_q <= '0;
    end else if (en_i) begin
      yuv_q <= yuv_d;
    end
  end

  assign yuv_o = yuv_q;

endmodule

`default_nettype wire

FILE: src/rys_back.sv
// second and third stages: luma shift, chroma products, yuv to rgb and clamp
`timescale 1ns / 1ps
`default_nettype none

module rys_back
  import rys_pkg::*;
#(
  parameter int CoefFracBits = COEF_FRAC_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire yuv_t                    yuv_i,
  input  wire logic signed [OFS_W-1:0] luma_offset_i,
  output logic                         valid_o,
  output logic        [CH_W-1:0]       gray_o,
  output logic        [CH_W-1:0]       red_o,
  output logic        [CH_W-1:0]       green_o,
  output logic        [CH_W-1:0]       blue_o
);

  localparam int PW     = CoefFracBits + 18;
  localparam int BW     = CoefFracBits + 20;
  localparam int BackSh = CoefFracBits + 4;

  localparam logic signed [PW-1:0] C1139 = PW'(milli_to_coef(1139, CoefFracBits));
  localparam logic signed [PW-1:0] C395  = PW'(milli_to_coef(395, CoefFracBits));
  localparam logic signed [PW-1:0] C581  = PW'(milli_to_coef(581, CoefFracBits));
  localparam logic signed [PW-1:0] C2032 = PW'(milli_to_coef(2032, CoefFracBits));

  logic signed [PW-1:0]      u_s, v_s;
  logic signed [YUV_W-1:0]   gray_sh;

  logic                      v2_q;
  logic signed [YS_W-1:0]    ys_q, ys_d;
  logic        [CH_W-1:0]    gray2_q, gray2_d;
  logic signed [PW-1:0]      pr_q, pr_d, pg_q, pg_d, pb_q, pb_d;

  logic signed [BW-1:0]      ybase, sum_r, sum_g, sum_b;
  logic signed [BW-1:0]      sh_r, sh_g, sh_b;

  logic                      v3_q;
  logic        [CH_W-1:0]    gray3_q, red3_q, green3_q, blue3_q;
  logic        [CH_W-1:0]    red3_d, green3_d, blue3_d;

  // stage two
  assign u_s     = PW'(yuv_i.u);
  assign v_s     = PW'(yuv_i.v);
  assign gray_sh = yuv_i.y >>> 4;

  assign ys_d    = YS_W'(yuv_i.y) + YS_W'(luma_offset_i);
  assign gray2_d = clamp_byte(CLAMP_W'(gray_sh));
  assign pr_d    = C1139 * v_s;
  assign pg_d    = -(C395 * u_s) - C581 * v_s;
  assign pb_d    = C2032 * u_s;

  // stage three
  assign ybase = BW'(ys_q) <<< CoefFracBits;
  assign sum_r = ybase + BW'(pr_q);
  assign sum_g = ybase + BW'(pg_q);
  assign sum_b = ybase + BW'(pb_q);
  assign sh_r  = sum_r >>> BackSh;
  assign sh_g  = sum_g >>> BackSh;
  assign sh_b  = sum_b >>> BackSh;

  assign red3_d   = clamp_byte(sh_r[CLAMP_W-1:0]);
  assign green3_d = clamp_byte(sh_g[CLAMP_W-1:0]);
  assign blue3_d  = clamp_byte(sh_b[CLAMP_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= yuv_i.valid;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ys_q     <= ys_d;
      gray2_q  <= gray2_d;
      pr_q     <= pr_d;
      pg_q     <= pg_d;
      pb_q     <= pb_d;
      gray3_q  <= gray2_q;
      red3_q   <= red3_d;
      green3_q <= green3_d;
      blue3_q  <= blue3_d;
    end
  end

  assign valid_o = v3_q;
  assign gray_o  = gray3_q;
  assign red_o   = red3_q;
  assign green_o = green3_q;
  assign blue_o  = blue3_q;

endmodule

`default_nettype wire

FILE: src/rgb_yuv_luma_shift_core.sv
// top level of the rgb yuv luma shift core
//
//   channel   dir   protocol      payload
//   pix_i     in    valid/ready   red_in, green_in, blue_in
//   res_o     out   valid/ready   gray_out, red_out, green_out, blue_out
//   apb       in    apb write     luma_offset at byte address 0
//
// one item per cycle sustained unless the output register holds an untaken item
// stages: the yuv stage, the chroma product stage and the output stage
// all stages advance together unless the output register holds an untaken item
// a stall freezes every stage, so nothing is lost or repeated
// reset clears the valid bits and the luma offset, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_yuv_luma_shift_core_defines.svh"

module rgb_yuv_luma_shift_core
  import rys_pkg::*;
#(
  parameter int CoefFracBits = COEF_FRAC_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rys_pix_if.sink          pix_i,
  rys_res_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic                    en;
  logic signed [OFS_W-1:0] luma_offset;
  yuv_t                    yuv;

  assign en          = !res_o.valid || res_o.ready;
  assign pix_i.ready = en;

  rys_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .luma_offset_o (luma_offset)
  );

  rys_fwd #(
    .CoefFracBits (CoefFracBits)
  ) u_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red_in),
    .green_i (pix_i.green_in),
    .blue_i  (pix_i.blue_in),
    .yuv_o   (yuv)
  );

  rys_back #(
    .CoefFracBits (CoefFracBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .yuv_i         (yuv),
    .luma_offset_i (luma_offset),
    .valid_o       (res_o.valid),
    .gray_o        (res_o.gray_out),
    .red_o         (res_o.red_out),
    .green_o       (res_o.green_out),
    .blue_o        (res_o.blue_out)
  );

  `RYS_ASSERT_IMP(a_no_accept_on_stall, clk_i, rst_ni, res_o.valid && !res_o.ready, !pix_i.ready)
  `RYS_ASSERT(a_item_arrives, clk_i, rst_ni, (pix_i.valid && pix_i.ready) ##1 pix_i.ready ##1 pix_i.ready |=> res_o.valid)
  `RYS_ASSERT_IMP(a_rise_needs_advance, clk_i, rst_ni, $rose(res_o.valid), $past(pix_i.ready))

endmodule

`default_nettype wire
